// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Simulation builds get the checks;
// synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// Checks that a trigger implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, trig, cons)

`endif

`endif

// ===== rtl/aeps_pkg.sv =====
`default_nettype none

package aeps_pkg;

    // Command codes of a request beat.
    typedef enum logic {
        CMD_ADD = 1'b0,
        CMD_GET = 1'b1
    } t_cmd;

    // Status codes of a result beat.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPRI = 2'd3
    } t_status;

    // Widths fixed by the interface.
    localparam int unsigned PORT_ID_W  = 8;
    localparam int unsigned PORT_LVL_W = 2;
    localparam int unsigned PRI_W      = 3;

    // Reset value of the levels-in-use register.
    localparam logic [PRI_W-1:0] LEVELS_RESET = 3'd4;

    // Decision of the control stage, registered into the result beat.
    typedef struct packed {
        t_status               status;
        logic [PORT_LVL_W-1:0] level;
        logic                  to_expired;
        logic                  swapped;
        logic                  popped;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/aeps_store.sv =====
`default_nettype none

module aeps_store #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port; the read port holds its data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/aeps_ctrl.sv =====
`default_nettype none

module aeps_ctrl #(
    parameter int unsigned MAX_LEVELS = 4,
    parameter int unsigned FIFO_DEPTH = 16,
    parameter int unsigned STORE_W    = 8,
    localparam int unsigned NQ    = 2 * MAX_LEVELS,
    localparam int unsigned DEPTH = NQ * FIFO_DEPTH,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic                        i_cmd,
    input  wire logic [STORE_W-1:0]          i_id,
    input  wire logic signed [aeps_pkg::PRI_W-1:0] i_dyn,
    input  wire logic [aeps_pkg::PRI_W-1:0]  i_stat,
    input  wire logic [aeps_pkg::PRI_W-1:0]  i_levels,
    output aeps_pkg::t_result                o_result,
    output logic                             o_we,
    output logic [AW-1:0]                    o_waddr,
    output logic [STORE_W-1:0]               o_wdata,
    output logic                             o_re,
    output logic [AW-1:0]                    o_raddr
);

    import aeps_pkg::*;

    localparam int unsigned QW    = $clog2(NQ);
    localparam int unsigned LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int unsigned PW    = $clog2(FIFO_DEPTH);
    localparam int unsigned CNTW  = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned EW    = 5;

    logic [PW-1:0]   r_head [NQ];
    logic [PW-1:0]   r_tail [NQ];
    logic [CNTW-1:0] r_cnt  [NQ];
    logic            r_bank;

    logic [NQ-1:0]    ne;
    logic [EW-1:0]    eff;
    logic             neg;
    logic [3:0]       add_lvl;
    logic             add_bad;
    logic             add_bank;
    logic [QW-1:0]    add_q;
    logic             add_full;
    logic             act_empty;
    logic             exp_empty;
    logic             sel_bank;
    logic             found;
    logic [LVL_W-1:0] pick;
    logic [QW-1:0]    get_q;
    logic             do_add;
    logic             do_pop;

    // Ring pointer step with wrap at the FIFO depth.
    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Non-empty flags and the effective level limit.
    always_comb begin
        for (int i = 0; i < NQ; i++) begin
            ne[i] = (r_cnt[i] != '0);
        end
        eff = ({2'b00, i_levels} > EW'(MAX_LEVELS)) ? EW'(MAX_LEVELS) : {2'b00, i_levels};
    end

    // Add path: target level, bank and FIFO.
    always_comb begin
        neg      = i_dyn[PRI_W-1];
        add_lvl  = neg ? ({1'b0, i_stat} - 4'd1) : {1'b0, i_dyn[PRI_W-1:0]};
        add_bad  = (neg && (i_stat == '0)) || ({1'b0, add_lvl} >= eff);
        add_bank = neg ? ~r_bank : r_bank;
        add_q    = QW'(add_bank ? MAX_LEVELS : 0) + QW'(add_lvl);
        add_full = (r_cnt[add_q] == CNTW'(FIFO_DEPTH));
    end

    // Get path: bank emptiness, swap choice and highest non-empty level.
    always_comb begin
        act_empty = 1'b1;
        exp_empty = 1'b1;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (ne[r_bank ? (MAX_LEVELS + l) : l]) begin
                act_empty = 1'b0;
            end
            if (ne[r_bank ? l : (MAX_LEVELS + l)]) begin
                exp_empty = 1'b0;
            end
        end
        sel_bank = act_empty ? ~r_bank : r_bank;
        found    = 1'b0;
        pick     = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (ne[sel_bank ? (MAX_LEVELS + l) : l]) begin
                found = 1'b1;
                pick  = LVL_W'(l);
            end
        end
        get_q = QW'(sel_bank ? MAX_LEVELS : 0) + QW'(pick);
    end

    assign do_add = i_fire && (i_cmd == CMD_ADD) && !add_bad && !add_full;
    assign do_pop = i_fire && (i_cmd == CMD_GET) && found;

    // Store access for this beat.
    always_comb begin
        o_we    = do_add;
        o_waddr = AW'(add_q) * AW'(FIFO_DEPTH) + AW'(r_tail[add_q]);
        o_wdata = i_id;
        o_re    = do_pop;
        o_raddr = AW'(get_q) * AW'(FIFO_DEPTH) + AW'(r_head[get_q]);
    end

    // Result fields of this beat.
    always_comb begin
        o_result = '{status: ST_OK, level: '0, to_expired: 1'b0, swapped: 1'b0,
                     popped: 1'b0};
        if (i_cmd == CMD_ADD) begin
            priority if (add_bad) begin
                o_result.status = ST_BADPRI;
            end else if (add_full) begin
                o_result.status = ST_FULL;
                o_result.level  = PORT_LVL_W'(add_lvl);
            end else begin
                o_result.level      = PORT_LVL_W'(add_lvl);
                o_result.to_expired = neg;
            end
        end else if (found) begin
            o_result.level   = PORT_LVL_W'(pick);
            o_result.swapped = act_empty;
            o_result.popped  = 1'b1;
        end else begin
            o_result.status = ST_EMPTY;
        end
    end

    // Pointer, count and bank state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NQ; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
            r_bank <= 1'b0;
        end else begin
            if (do_add) begin
                r_tail[add_q] <= ptr_next(r_tail[add_q]);
                r_cnt[add_q]  <= r_cnt[add_q] + CNTW'(1);
            end
            if (do_pop) begin
                r_head[get_q] <= ptr_next(r_head[get_q]);
                r_cnt[get_q]  <= r_cnt[get_q] - CNTW'(1);
                if (act_empty && !exp_empty) begin
                    r_bank <= ~r_bank;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/active_expired_priority_scheduler.sv =====
`default_nettype none

// Two-bank multilevel scheduler: add and get requests are taken one per clock
// while the result register is free or taken. Each result beat passes the request
// register, then the decision stage on the per-FIFO counts that also drives the
// single-write, registered-read task store, then the result register. The store
// holds 2*MAX_LEVELS FIFOs of FIFO_DEPTH ids and needs no clearing pass: pointers
// and counts reset at once, and an entry is only read after it was written. Write
// levels_in_use only while no request is in flight.
module active_expired_priority_scheduler #(
    parameter int unsigned MAX_LEVELS = 4,
    parameter int unsigned FIFO_DEPTH = 16,
    parameter int unsigned ID_WIDTH   = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [aeps_pkg::PRI_W-1:0]   i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_command,
    input  wire logic [aeps_pkg::PORT_ID_W-1:0] i_task_id,
    input  wire logic signed [aeps_pkg::PRI_W-1:0] i_dyn_priority,
    input  wire logic [aeps_pkg::PRI_W-1:0]   i_static_priority,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [1:0]                        o_status,
    output logic [aeps_pkg::PORT_ID_W-1:0]    o_chosen_id,
    output logic [aeps_pkg::PORT_LVL_W-1:0]   o_level_used,
    output logic                              o_to_expired,
    output logic                              o_banks_swapped
);

    import aeps_pkg::*;

    localparam int unsigned STORE_W = (ID_WIDTH < PORT_ID_W) ? ID_WIDTH : PORT_ID_W;
    localparam int unsigned DEPTH   = 2 * MAX_LEVELS * FIFO_DEPTH;
    localparam int unsigned AW      = $clog2(DEPTH);

    logic [PRI_W-1:0]        r_levels;
    logic                    r_iv;
    logic                    r_cmd;
    logic [STORE_W-1:0]      r_tid;
    logic signed [PRI_W-1:0] r_dyn;
    logic [PRI_W-1:0]        r_stat;
    logic                    r_ov;
    t_result                 r_res;
    logic [STORE_W-1:0]      r_oid;

    logic                    adv;
    logic                    fire;
    t_result                 n_res;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [STORE_W-1:0]      wdata;
    logic                    re;
    logic [AW-1:0]           raddr;
    logic [STORE_W-1:0]      rdata;

    // The result register frees when empty or taken; the request register
    // then moves on.
    assign adv        = !r_ov || i_out_ready;
    assign fire       = r_iv && adv;
    assign o_in_ready = !r_iv || adv;

    // Levels-in-use register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVELS_RESET;
        end else if (i_cfg_we) begin
            r_levels <= i_cfg_data;
        end
    end

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (o_in_ready) begin
            r_iv <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_cmd  <= i_command;
            r_tid  <= i_task_id[STORE_W-1:0];
            r_dyn  <= i_dyn_priority;
            r_stat <= i_static_priority;
        end
    end

    aeps_ctrl #(
        .MAX_LEVELS(MAX_LEVELS),
        .FIFO_DEPTH(FIFO_DEPTH),
        .STORE_W   (STORE_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (r_cmd),
        .i_id    (r_tid),
        .i_dyn   (r_dyn),
        .i_stat  (r_stat),
        .i_levels(r_levels),
        .o_result(n_res),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_re    (re),
        .o_raddr (raddr)
    );

    aeps_store #(
        .DEPTH(DEPTH),
        .WIDTH(STORE_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Result register; a popped id comes from the store's read register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_iv;
        end
        if (fire) begin
            r_res <= n_res;
            r_oid <= (r_cmd == CMD_ADD) ? r_tid : '0;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_res.status;
    assign o_chosen_id     = r_res.popped ? PORT_ID_W'(rdata) : PORT_ID_W'(r_oid);
    assign o_level_used    = r_res.level;
    assign o_to_expired    = r_res.to_expired;
    assign o_banks_swapped = r_res.swapped;

    `include "assert_macros.svh"

    // An empty get carries no id and no swap.
    `ASSERT_IMPLIES(a_empty_clean, i_clk, i_rst_n, o_out_valid && (o_status == ST_EMPTY), (o_chosen_id == '0) && !o_banks_swapped && (o_level_used == '0))
    // Only a successful add lands in the expired bank.
    `ASSERT_IMPLIES(a_expired_ok, i_clk, i_rst_n, o_out_valid && o_to_expired, o_status == ST_OK)
    // A bank swap only comes with a successful get.
    `ASSERT_IMPLIES(a_swap_ok, i_clk, i_rst_n, o_out_valid && o_banks_swapped, (o_status == ST_OK) && !o_to_expired)
    // The store is never written and read in the same cycle.
    `ASSERT_ALWAYS(a_one_port, i_clk, i_rst_n, !(we && re))

endmodule

`default_nettype wire

// ===== verif/tb_active_expired_priority_scheduler.sv =====
`default_nettype none

module tb_active_expired_priority_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import aeps_pkg::*;

    localparam int NUM_LEVELS  = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 2 * NUM_LEVELS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_GAP   = 4;

    // One request beat as it is driven onto the input channel.
    typedef struct {
        t_cmd              cmd;
        logic [7:0]        id;
        logic signed [2:0] dyn;
        logic [2:0]        stat;
    } t_request;

    // One result beat, field by field.
    typedef struct packed {
        t_status    status;
        logic [7:0] id;
        logic [1:0] level;
        logic       to_exp;
        logic       swapped;
    } t_dispatch;

    // Block ports.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [PRI_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_command = 1'b0;
    logic [PORT_ID_W-1:0] i_task_id = '0;
    logic signed [PRI_W-1:0] i_dyn_priority = '0;
    logic [PRI_W-1:0]     i_static_priority = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_status;
    logic [PORT_ID_W-1:0] o_chosen_id;
    logic [PORT_LVL_W-1:0] o_level_used;
    logic                 o_to_expired;
    logic                 o_banks_swapped;

    // Scheduler state as the predictor sees it.
    logic [7:0] fifo_store [NUM_QUEUES*QUEUE_DEPTH];
    int         fifo_head  [NUM_QUEUES] = '{default: 0};
    int         fifo_tail  [NUM_QUEUES] = '{default: 0};
    int         fifo_fill  [NUM_QUEUES] = '{default: 0};
    logic       live_bank  = 1'b0;
    logic [2:0] levels_reg = LEVELS_RESET;

    // Stimulus and scoreboard bookkeeping.
    t_request  request_q[$];
    t_dispatch expected_dispatch_q[$];
    int        send_idle_pct = 20;
    int        recv_idle_pct = 82;
    logic      in_beat = 1'b0;
    int        requests_queued = 0;
    int        results_matched = 0;
    int        mismatches = 0;
    int        cycle_count = 0;
    int        status_seen [4] = '{default: 0};
    int        swaps_seen = 0;
    int        phase_levels [9] = '{4, 1, 7, 2, 0, 3, 5, 1, 4};

    active_expired_priority_scheduler dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_task_id         (i_task_id),
        .i_dyn_priority    (i_dyn_priority),
        .i_static_priority (i_static_priority),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_chosen_id       (o_chosen_id),
        .o_level_used      (o_level_used),
        .o_to_expired      (o_to_expired),
        .o_banks_swapped   (o_banks_swapped)
    );

    // Clock generation.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // A bank is empty when none of its level queues holds a task.
    function automatic logic bank_is_empty(logic bank);
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (fifo_fill[int'(bank) * NUM_LEVELS + l] != 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one request to the predicted scheduler state and returns its result.
    function automatic t_dispatch dispatch_request(t_request req);
        t_dispatch res;
        int        eff;
        int        lvl;
        int        q;
        logic      exp;
        logic      bank;
        res = '{status: ST_OK, id: 8'd0, level: 2'd0, to_exp: 1'b0, swapped: 1'b0};
        eff = (levels_reg > NUM_LEVELS) ? NUM_LEVELS : int'(levels_reg);
        if (req.cmd == CMD_ADD) begin
            res.id = req.id;
            if (req.dyn < 0) begin
                lvl = int'(req.stat) - 1;
                exp = 1'b1;
            end else begin
                lvl = int'(req.dyn);
                exp = 1'b0;
            end
            if (lvl < 0 || lvl >= eff) begin
                res.status = ST_BADPRI;
                return res;
            end
            bank = exp ? ~live_bank : live_bank;
            q = int'(bank) * NUM_LEVELS + lvl;
            res.level = lvl[1:0];
            if (fifo_fill[q] >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
                return res;
            end
            fifo_store[q * QUEUE_DEPTH + fifo_tail[q]] = req.id;
            fifo_tail[q] = (fifo_tail[q] + 1) % QUEUE_DEPTH;
            fifo_fill[q]++;
            res.to_exp = exp;
            return res;
        end
        // A get swaps the banks first when only the expired bank holds tasks.
        if (bank_is_empty(live_bank)) begin
            if (bank_is_empty(~live_bank)) begin
                res.status = ST_EMPTY;
                return res;
            end
            live_bank = ~live_bank;
            res.swapped = 1'b1;
        end
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            q = int'(live_bank) * NUM_LEVELS + l;
            if (fifo_fill[q] != 0) begin
                res.id = fifo_store[q * QUEUE_DEPTH + fifo_head[q]];
                res.level = l[1:0];
                fifo_head[q] = (fifo_head[q] + 1) % QUEUE_DEPTH;
                fifo_fill[q]--;
                return res;
            end
        end
        res.status = ST_EMPTY;
        return res;
    endfunction

    // Request driver and result receiver, both changing at the falling edge.
    always @(negedge i_clk) begin : drive_channels
        t_request req;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || in_beat) begin
                if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req = request_q[0];
                    request_q.delete(0);
                    i_in_valid        <= 1'b1;
                    i_command         <= req.cmd;
                    i_task_id         <= req.id;
                    i_dyn_priority    <= req.dyn;
                    i_static_priority <= req.stat;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: checks each result beat, then predicts each accepted request beat.
    always @(posedge i_clk) begin : watch_beats
        t_dispatch got;
        t_dispatch want;
        t_request  req;
        if (!i_rst_n) begin
            in_beat <= 1'b0;
        end else begin
            in_beat <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                got = '{status: t_status'(o_status), id: o_chosen_id, level: o_level_used,
                        to_exp: o_to_expired, swapped: o_banks_swapped};
                if (expected_dispatch_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result beat with none expected: st=%0d id=%0d lvl=%0d",
                                 $realtime, got.status, got.id, got.level);
                end else begin
                    want = expected_dispatch_q[0];
                    expected_dispatch_q.delete(0);
                    results_matched++;
                    status_seen[want.status]++;
                    if (want.swapped) swaps_seen++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] mismatch: exp st=%0d id=%0d lvl=%0d exp=%0d sw=%0d",
                                     $realtime, want.status, want.id, want.level, want.to_exp,
                                     want.swapped);
                        if (mismatches <= 10)
                            $display("           got st=%0d id=%0d lvl=%0d exp=%0d sw=%0d",
                                     got.status, got.id, got.level, got.to_exp, got.swapped);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                req = '{cmd: t_cmd'(i_command), id: i_task_id, dyn: i_dyn_priority,
                        stat: i_static_priority};
                want = dispatch_request(req);
                expected_dispatch_q = {expected_dispatch_q, want};
            end
        end
    end

    // Cycle counter with a hard limit on the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, requests_queued - results_matched);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_request(t_cmd cmd, logic [7:0] id, logic signed [2:0] dyn,
                                 logic [2:0] stat);
        t_request req;
        req = '{cmd: cmd, id: id, dyn: dyn, stat: stat};
        request_q = {request_q, req};
        requests_queued++;
    endtask

    // Random requests in bursts that lean toward filling, draining or neither.
    task automatic queue_random_batch(int n);
        int                burst_left = 0;
        int                add_pct = 50;
        int                pick;
        t_cmd              cmd;
        logic signed [2:0] dyn;
        logic [2:0]        stat;
        for (int k = 0; k < n; k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 50);
                case ($urandom_range(0, 2))
                    0: add_pct = 90;
                    1: add_pct = 50;
                    default: add_pct = 15;
                endcase
            end
            burst_left--;
            cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_GET;
            pick = $urandom_range(0, 99);
            if (pick < 25) dyn = -3'sd1;
            else if (pick < 90) dyn = 3'($urandom_range(0, 3));
            else dyn = 3'($urandom);
            if ($urandom_range(0, 9) == 0) stat = 3'($urandom);
            else stat = 3'($urandom_range(1, 4));
            queue_request(cmd, 8'($urandom), dyn, stat);
        end
    endtask

    // Waits at the falling edge until every queued request has produced its result.
    task automatic wait_drained();
        do @(negedge i_clk); while (results_matched != requests_queued);
    endtask

    // One phase: settle, write levels_in_use, set the idling mix, queue requests.
    task automatic run_phase(logic [2:0] levels, int mode, int n);
        wait_drained();
        repeat (DRAIN_GAP) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= levels;
        levels_reg = levels;
        case (mode)
            0: begin send_idle_pct <= 20; recv_idle_pct <= 82; end
            1: begin send_idle_pct <= 82; recv_idle_pct <= 20; end
            default: begin send_idle_pct <= 0; recv_idle_pct <= 0; end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        queue_random_batch(n);
    endtask

    // Sequence: reset, directed requests, then random phases over several settings.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty get, field extremes, expired refill, bad levels, swap, drain.
        queue_request(CMD_GET, 8'h00, 3'sd0, 3'd1);
        queue_request(CMD_ADD, 8'h00, 3'sd0, 3'd1);
        queue_request(CMD_ADD, 8'hFF, 3'sd3, 3'd4);
        queue_request(CMD_ADD, 8'hA5, -3'sd1, 3'd1);
        queue_request(CMD_ADD, 8'h5A, -3'sd1, 3'd4);
        queue_request(CMD_ADD, 8'h11, -3'sd1, 3'd0);
        queue_request(CMD_ADD, 8'h22, -3'sd1, 3'd5);
        queue_request(CMD_ADD, 8'h33, -3'sd4, 3'd7);
        queue_request(CMD_ADD, 8'h44, -3'sd2, 3'd2);
        queue_request(CMD_ADD, 8'h66, 3'sd2, 3'd6);
        for (int k = 0; k < 7; k++) queue_request(CMD_GET, 8'($urandom), 3'sd0, 3'd1);

        for (int p = 0; p < 9; p++) run_phase(3'(phase_levels[p]), p / 3, 156);

        wait_drained();
        repeat (10) @(negedge i_clk);
        $display("Ran %0d requests in %0d cycles, levels_in_use from 0 to 7, three idling mixes.",
                 requests_queued, cycle_count);
        $display("Results: %0d ok, %0d empty, %0d full, %0d bad level, %0d bank swaps.",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_BADPRI], swaps_seen);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatched result beats", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/aeps_pkg.sv
rtl/aeps_store.sv
rtl/aeps_ctrl.sv
rtl/active_expired_priority_scheduler.sv
verif/tb_active_expired_priority_scheduler.sv
